// ----- rtl/core/hcfc_pkg.sv -----
// Shared types and constants for the hill-climbing focus controller.
package hcfc_pkg;

	localparam int HISTORY_DEPTH_DEF = 10;

	localparam int SHARP_W   = 24;
	localparam int STEPS_W   = 8;
	localparam int OSC_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	localparam logic [STEPS_W-1:0] MAX_STEPS_RST = 8'd30;
	localparam logic [OSC_W-1:0]   OSC_LIMIT_RST = 5'd2;
	localparam logic [STEPS_W-1:0] STEP_COUNT_MAX = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OSC_LIMIT = 1'b1;

	localparam logic MODE_START     = 1'b0;
	localparam logic MODE_MOVE_DONE = 1'b1;

	localparam logic DIR_FORWARD = 1'b1;

	typedef enum logic [1:0] {
		CAUSE_NONE        = 2'd0,
		CAUSE_STEP_LIMIT  = 2'd1,
		CAUSE_OSCILLATION = 2'd2
	} stop_cause_t;

	typedef struct packed {
		logic [STEPS_W-1:0] max_steps;
		logic [OSC_W-1:0]   oscillation_limit;
	} cfg_t;

	typedef struct packed {
		logic        motor_step;
		logic        step_direction;
		logic        focusing;
		stop_cause_t stop_cause;
	} result_t;

endpackage

// ----- rtl/core/hill_climb_focus_controller_top.sv -----
// Hill-climbing autofocus controller top level: input register, decision core, result register.
// Accepts one item per clock cycle while in_stall is low and returns exactly one result per item.
// An accepted item is held in the input register; the decision core evaluates it against the
// focus state and the result register captures the result once it is empty or its result is
// being taken, then presents it on the output until it is taken. The input and result
// registers form a two-entry buffer: the input stalls only while both hold an item and the
// output is stalled. Configuration writes take effect for items that reach the decision core
// after the write.
module hill_climb_focus_controller_top
	import hcfc_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [SHARP_W-1:0]   sharpness,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 motor_step,
	output logic                 step_direction,
	output logic                 focusing,
	output logic [1:0]           stop_cause,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic               valid_s1;
	logic               mode_s1;
	logic [SHARP_W-1:0] sharp_s1;
	logic               valid_s2;
	result_t            res_s2;
	result_t            res;
	cfg_t               cfg;
	logic               advance;
	logic               accept;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	hcfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hcfc_core #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (advance),
		.mode      (mode_s1),
		.sharpness (sharp_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			sharp_s1 <= sharpness;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign motor_step     = res_s2.motor_step;
	assign step_direction = res_s2.step_direction;
	assign focusing       = res_s2.focusing;
	assign stop_cause     = res_s2.stop_cause;

endmodule

// ----- rtl/core/hcfc_cfg_regs.sv -----
// Configuration register file: step limit and oscillation limit.
module hcfc_cfg_regs
	import hcfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	logic [STEPS_W-1:0] max_steps_q;
	logic [OSC_W-1:0]   osc_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steps_q <= MAX_STEPS_RST;
			osc_limit_q <= OSC_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_STEPS: begin
					max_steps_q <= cfg_data[STEPS_W-1:0];
				end
				REG_OSC_LIMIT: begin
					osc_limit_q <= cfg_data[OSC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.max_steps         = max_steps_q;
	assign cfg.oscillation_limit = osc_limit_q;

endmodule

// ----- rtl/core/hcfc_core.sv -----
// Focus state registers and the combinational hill-climb decision logic.
module hcfc_core
	import hcfc_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic               mode,
	input  logic [SHARP_W-1:0] sharpness,
	input  cfg_t               cfg,
	output result_t            res
);

	localparam int FW = $clog2(HISTORY_DEPTH + 1);
	localparam int SW = FW + 1;
	localparam int CW = (SW > OSC_W) ? SW : OSC_W;
	localparam logic [FW-1:0] FILL_FULL = FW'(HISTORY_DEPTH);
	localparam logic [SW-1:0] DEPTH_S   = SW'(HISTORY_DEPTH);

	logic                     active_q;
	logic                     direction_q;
	logic [STEPS_W-1:0]       step_count_q;
	logic [SHARP_W-1:0]       last_sharp_q;
	logic [HISTORY_DEPTH-1:0] hist_q;
	logic [FW-1:0]            fill_q;

	logic                     active_d;
	logic                     direction_d;
	logic [STEPS_W-1:0]       step_count_d;
	logic [SHARP_W-1:0]       last_sharp_d;
	logic [HISTORY_DEPTH-1:0] hist_d;
	logic [FW-1:0]            fill_d;

	logic                     new_dir;
	logic [HISTORY_DEPTH-1:0] new_hist;
	logic [FW-1:0]            ones;
	logic [SW-1:0]            twice_ones;
	logic [SW-1:0]            abs_sum;
	logic                     was_full;
	logic                     osc_hit;

	function automatic logic [FW-1:0] count_ones(input logic [HISTORY_DEPTH-1:0] v);
		logic [FW-1:0] n;
		n = '0;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			n = n + FW'(v[i]);
		end
		return n;
	endfunction

	assign new_dir    = direction_q ^ (last_sharp_q > sharpness);
	assign new_hist   = {hist_q[HISTORY_DEPTH-2:0], new_dir};
	assign ones       = count_ones(new_hist);
	assign twice_ones = {ones, 1'b0};
	assign abs_sum    = (twice_ones >= DEPTH_S) ? (twice_ones - DEPTH_S)
	                                            : (DEPTH_S - twice_ones);
	assign was_full   = (fill_q >= FILL_FULL);
	assign osc_hit    = was_full && (CW'(abs_sum) < CW'(cfg.oscillation_limit));

	always_comb begin
		active_d     = active_q;
		direction_d  = direction_q;
		step_count_d = step_count_q;
		last_sharp_d = last_sharp_q;
		hist_d       = hist_q;
		fill_d       = fill_q;
		res          = '0;
		res.stop_cause = CAUSE_NONE;
		if (mode == MODE_START) begin
			active_d           = 1'b1;
			direction_d        = DIR_FORWARD;
			step_count_d       = '0;
			last_sharp_d       = sharpness;
			hist_d             = '0;
			fill_d             = '0;
			res.motor_step     = 1'b1;
			res.step_direction = DIR_FORWARD;
		end else if (active_q) begin
			if (step_count_q > cfg.max_steps) begin
				active_d       = 1'b0;
				res.stop_cause = CAUSE_STEP_LIMIT;
			end else begin
				direction_d  = new_dir;
				last_sharp_d = sharpness;
				if (step_count_q != STEP_COUNT_MAX) begin
					step_count_d = step_count_q + 1'b1;
				end
				hist_d             = new_hist;
				res.motor_step     = 1'b1;
				res.step_direction = new_dir;
				if (!was_full) begin
					fill_d = fill_q + 1'b1;
				end else if (osc_hit) begin
					active_d       = 1'b0;
					res.stop_cause = CAUSE_OSCILLATION;
				end
			end
		end
		res.focusing = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			direction_q  <= DIR_FORWARD;
			step_count_q <= '0;
			last_sharp_q <= '0;
			hist_q       <= '0;
			fill_q       <= '0;
		end else if (take) begin
			active_q     <= active_d;
			direction_q  <= direction_d;
			step_count_q <= step_count_d;
			last_sharp_q <= last_sharp_d;
			hist_q       <= hist_d;
			fill_q       <= fill_d;
		end
	end

endmodule

// ----- rtl/core/hcfc_checker.sv -----
// Port-level checker for the focus controller, bound to the top level.
module hcfc_checker
	import hcfc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       motor_step,
	input logic       step_direction,
	input logic       focusing,
	input logic [1:0] stop_cause
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(motor_step)
			&& $stable(step_direction) && $stable(focusing) && $stable(stop_cause))
		else $error("result changed while stalled");

	a_dir_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !motor_step |-> !step_direction)
		else $error("direction set without a motor step");

	a_stop_ends_focus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (stop_cause != CAUSE_NONE) |-> !focusing)
		else $error("stop cause reported while still focusing");

	a_limit_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (stop_cause == CAUSE_STEP_LIMIT) |-> !motor_step)
		else $error("step commanded on step limit stop");

	a_osc_with_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (stop_cause == CAUSE_OSCILLATION) |-> motor_step)
		else $error("oscillation stop without a motor step");

endmodule

bind hill_climb_focus_controller_top hcfc_checker u_hcfc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.motor_step     (motor_step),
	.step_direction (step_direction),
	.focusing       (focusing),
	.stop_cause     (stop_cause)
);

// ----- test/tb_top.sv -----
// Testbench for the hill-climbing focus controller: random and directed items, scoreboard check.
`timescale 1ns / 1ps

module tb_top;
	import hcfc_pkg::*;

	localparam int HIST         = HISTORY_DEPTH_DEF;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct {
		logic               mode;
		logic [SHARP_W-1:0] sharp;
	} focus_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 mode = 1'b0;
	logic [SHARP_W-1:0]   sharpness = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 motor_step;
	logic                 step_direction;
	logic                 focusing;
	logic [1:0]           stop_cause;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	hill_climb_focus_controller_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.sharpness      (sharpness),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.motor_step     (motor_step),
		.step_direction (step_direction),
		.focusing       (focusing),
		.stop_cause     (stop_cause),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #6 clk = ~clk;

	focus_item_t frame_queue[$];
	result_t     expected_focus[$];

	int failures     = 0;
	int cycles       = 0;
	int n_accepted   = 0;
	int n_offered    = 0;
	int results_done = 0;
	bit quiet        = 1'b0;

	// focus state mirror
	logic [STEPS_W-1:0] lim_steps = MAX_STEPS_RST;
	logic [OSC_W-1:0]   lim_osc   = OSC_LIMIT_RST;
	logic               fc_active = 1'b0;
	logic               fc_dir    = DIR_FORWARD;
	logic [STEPS_W-1:0] fc_count  = '0;
	logic [SHARP_W-1:0] fc_last   = '0;
	logic [HIST-1:0]    fc_hist   = '0;
	int                 fc_fill   = 0;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic predict_focus(input logic m, input logic [SHARP_W-1:0] s);
		result_t r;
		bit      was_full;
		int      sum;
		r.motor_step     = 1'b0;
		r.step_direction = 1'b0;
		r.stop_cause     = CAUSE_NONE;
		if (m == MODE_START) begin
			fc_last          = s;
			fc_active        = 1'b1;
			fc_dir           = DIR_FORWARD;
			fc_count         = '0;
			fc_hist          = '0;
			fc_fill          = 0;
			r.motor_step     = 1'b1;
			r.step_direction = DIR_FORWARD;
		end else if (fc_active) begin
			if (fc_count > lim_steps) begin
				fc_active    = 1'b0;
				r.stop_cause = CAUSE_STEP_LIMIT;
			end else begin
				was_full = (fc_fill >= HIST);
				if (fc_last > s)
					fc_dir = ~fc_dir;
				fc_last = s;
				if (fc_count != STEP_COUNT_MAX)
					fc_count = fc_count + 1'b1;
				r.motor_step     = 1'b1;
				r.step_direction = fc_dir;
				fc_hist = {fc_hist[HIST-2:0], fc_dir};
				if (!was_full) begin
					fc_fill++;
				end else begin
					sum = 2 * $countones(fc_hist) - HIST;
					if (sum < 0)
						sum = -sum;
					if (sum < int'(lim_osc)) begin
						fc_active    = 1'b0;
						r.stop_cause = CAUSE_OSCILLATION;
					end
				end
			end
		end
		r.focusing = fc_active;
		expected_focus.insert(expected_focus.size(), r);
	endtask

	// input side
	int tx_gap = 0;

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_focus(mode, sharpness);
			frame_queue.delete(0);
			n_accepted++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(in_valid && n_accepted != n_offered)) begin
			if (tx_gap > 0) begin
				in_valid <= 1'b0;
				tx_gap--;
			end else if (frame_queue.size() > 0) begin
				in_valid  <= 1'b1;
				mode      <= frame_queue[0].mode;
				sharpness <= frame_queue[0].sharp;
				n_offered++;
				tx_gap = quiet ? 0 : gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side
	int rx_gap  = 0;
	int rx_hold = 0;
	int hold_at = 150;

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_hold > 0) begin
				out_stall <= 1'b1;
				rx_hold--;
			end else if (results_done >= hold_at) begin
				out_stall <= 1'b1;
				rx_hold = 100;
				hold_at = (hold_at == 150) ? 600 : 32'h7FFF_FFFF;
			end else if (rx_gap > 0) begin
				out_stall <= 1'b1;
				rx_gap--;
			end else begin
				out_stall <= 1'b0;
				rx_gap = quiet ? 0 : gap_len();
			end
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (out_valid && !out_stall) begin
			results_done++;
			if (expected_focus.size() == 0) begin
				$error("unexpected result item");
				failures++;
			end else begin
				e = expected_focus.pop_front();
				if (motor_step !== e.motor_step) begin
					$error("motor_step: expected %0d, actual %0d", e.motor_step, motor_step);
					failures++;
				end
				if (step_direction !== e.step_direction) begin
					$error("step_direction: expected %0d, actual %0d",
						e.step_direction, step_direction);
					failures++;
				end
				if (focusing !== e.focusing) begin
					$error("focusing: expected %0d, actual %0d", e.focusing, focusing);
					failures++;
				end
				if (stop_cause !== e.stop_cause) begin
					$error("stop_cause: expected %0d, actual %0d", e.stop_cause, stop_cause);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic push_item(input logic m, input logic [SHARP_W-1:0] s);
		focus_item_t it;
		it.mode  = m;
		it.sharp = s;
		frame_queue.insert(frame_queue.size(), it);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == REG_MAX_STEPS)
			lim_steps = val[STEPS_W-1:0];
		else if (idx == REG_OSC_LIMIT)
			lim_osc = val[OSC_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (frame_queue.size() != 0 || expected_focus.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// start, then a sharpness walk that mostly climbs, with some noise
	task automatic add_session(input int n_moves);
		int cur;
		int r;
		cur = $urandom_range(0, 24'hFFFFFF);
		push_item(MODE_START, SHARP_W'(cur));
		for (int i = 0; i < n_moves; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				cur = $urandom_range(0, 24'hFFFFFF);
				push_item(MODE_START, SHARP_W'(cur));
			end else if (r < 8) begin
				cur = $urandom_range(0, 24'hFFFFFF);
				push_item(MODE_MOVE_DONE, SHARP_W'(cur));
			end else if (r < 11) begin
				cur = (r == 9) ? 0 : 24'hFFFFFF;
				push_item(MODE_MOVE_DONE, SHARP_W'(cur));
			end else begin
				cur = cur + $urandom_range(0, 2000) - 700;
				if (cur < 0) cur = 0;
				if (cur > 24'hFFFFFF) cur = 24'hFFFFFF;
				push_item(MODE_MOVE_DONE, SHARP_W'(cur));
			end
		end
	endtask

	task automatic random_phase(input int budget);
		int n;
		int done;
		done = 0;
		while (done < budget) begin
			if ($urandom_range(0, 7) == 0)
				push_item(MODE_MOVE_DONE, SHARP_W'($urandom_range(0, 24'hFFFFFF)));
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(3, 25);
			add_session(n);
			done += n + 1;
		end
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: idle move, start, climb, fall, restart, steady falls
		push_item(MODE_MOVE_DONE, 24'hFFFFFF);
		push_item(MODE_START, 24'h000000);
		push_item(MODE_MOVE_DONE, 24'hFFFFFF);
		push_item(MODE_MOVE_DONE, 24'h000000);
		push_item(MODE_START, 24'hFFFFFF);
		for (int i = 0; i < 12; i++)
			push_item(MODE_MOVE_DONE, SHARP_W'(24'hFFFFFE - i));
		push_item(MODE_MOVE_DONE, 24'h000000);
		drain();

		// step limit at zero
		cfg_write(REG_MAX_STEPS, 8'h00);
		cfg_write(REG_OSC_LIMIT, 8'h00);
		push_item(MODE_START, 24'h000005);
		repeat (3) push_item(MODE_MOVE_DONE, 24'h000005);
		drain();
		random_phase(60);

		// count saturation, no idling
		cfg_write(REG_MAX_STEPS, 8'hFF);
		quiet = 1'b1;
		push_item(MODE_START, SHARP_W'($urandom_range(0, 24'hFFFFFF)));
		for (int i = 0; i < 270; i++)
			push_item(MODE_MOVE_DONE, SHARP_W'($urandom_range(0, 24'hFFFFFF)));
		drain();
		quiet = 1'b0;

		cfg_write(REG_OSC_LIMIT, 8'h10);
		random_phase(90);

		cfg_write(REG_MAX_STEPS, 8'h0C);
		cfg_write(REG_OSC_LIMIT, 8'hE5);
		random_phase(120);

		cfg_write(REG_MAX_STEPS, 8'd30);
		cfg_write(REG_OSC_LIMIT, 8'd2);
		quiet = 1'b1;
		random_phase(120);
		quiet = 1'b0;

		repeat (2) begin
			cfg_write(REG_MAX_STEPS, CFG_DAT_W'($urandom_range(0, 255)));
			cfg_write(REG_OSC_LIMIT, CFG_DAT_W'($urandom_range(0, 255)));
			random_phase(120);
		end

		cfg_write(REG_MAX_STEPS, 8'h80);
		cfg_write(REG_OSC_LIMIT, 8'hFF);
		random_phase(80);

		repeat (20) @(posedge clk);
		if (failures == 0 && expected_focus.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/hcfc_pkg.sv
rtl/core/hcfc_cfg_regs.sv
rtl/core/hcfc_core.sv
rtl/core/hill_climb_focus_controller_top.sv
rtl/core/hcfc_checker.sv
test/tb_top.sv
